// File: hdl/top_k_score_table_top_defines.svh
// shared assertion macros for the ranked score table
`ifndef TOP_K_SCORE_TABLE_TOP_DEFINES_SVH
`define TOP_K_SCORE_TABLE_TOP_DEFINES_SVH

// property that must hold at every clock edge outside reset
`define TKST_ASSERT(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// condition that must be followed by another in the next cycle
`define TKST_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// File: hdl/tkst_pkg.sv
`default_nettype none
package tkst_pkg;

	// default geometry
	localparam int DEF_TABLE_DEPTH = 10;
	localparam int DEF_KEY_BITS    = 32;
	localparam int DEF_SCORE_BITS  = 32;

	// stream field widths
	localparam int IN_TDATA_W  = 64;
	localparam int OUT_TDATA_W = 40;

	// item kinds carried in tuser
	localparam logic KIND_INSERT = 1'b0;
	localparam logic KIND_LOOKUP = 1'b1;

	// sequencer states
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_INS_CMP,
		ST_INS_PUT,
		ST_LKP_CMP,
		ST_DONE
	} state_t;

endpackage
`default_nettype wire

// File: hdl/tkst_entry_ram.sv
`default_nettype none
module tkst_entry_ram #(
	parameter int DEPTH  = tkst_pkg::DEF_TABLE_DEPTH,
	parameter int WIDTH  = tkst_pkg::DEF_KEY_BITS + tkst_pkg::DEF_SCORE_BITS,
	parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire logic              clk,
	input  wire logic              wr_en,
	input  wire logic [ADDR_W-1:0] wr_addr,
	input  wire logic [WIDTH-1:0]  wr_data,
	input  wire logic [ADDR_W-1:0] rd_addr,
	output logic      [WIDTH-1:0]  rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rd_data_q;

	// single write port
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
	end

	// registered read, data is valid in the cycle after the address
	always_ff @(posedge clk) begin
		rd_data_q <= mem_q[rd_addr];
	end

	assign rd_data = rd_data_q;

endmodule
`default_nettype wire

// File: hdl/top_k_score_table_top.sv
`default_nettype none
`include "top_k_score_table_top_defines.svh"
// Ranked score table: keeps up to TABLE_DEPTH key/score entries in descending
// score order in a one-port-write, one-port-read RAM with a registered read.
// An insert walks the table from the bottom entry upward, moving each
// lower-scored entry down one slot, and drops the new entry into place below
// all entries of equal or higher score; on a full table the bottom entry
// falls off, or the new one if it does not beat it. A lookup walks from the
// top and reports the first matching key. The walk reads one RAM entry per
// cycle. A finished item waits in the done state until the output register
// is free, and the sequencer then returns to idle. A new item is taken only
// while the sequencer is idle; the result register lets it be taken while
// the previous result is still waiting on the output.
module top_k_score_table_top #(
	parameter int TABLE_DEPTH = tkst_pkg::DEF_TABLE_DEPTH,
	parameter int KEY_BITS    = tkst_pkg::DEF_KEY_BITS,
	parameter int SCORE_BITS  = tkst_pkg::DEF_SCORE_BITS
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         s_axis_tvalid,
	output logic                              s_axis_tready,
	// [31:0] player_key, [63:32] new_score
	input  wire logic [tkst_pkg::IN_TDATA_W-1:0]  s_axis_tdata,
	// [0] kind
	input  wire logic                         s_axis_tuser,
	output logic                              m_axis_tvalid,
	input  wire logic                         m_axis_tready,
	// [31:0] best_score, [35:32] entry_count, [39:36] zero
	output logic [tkst_pkg::OUT_TDATA_W-1:0]  m_axis_tdata,
	// [0] hit
	output logic                              m_axis_tuser
);

	localparam int CNT_W  = $clog2(TABLE_DEPTH + 1);
	localparam int IDX_W  = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
	localparam int ENT_W  = KEY_BITS + SCORE_BITS;

	tkst_pkg::state_t state_q, state_d;

	logic [CNT_W-1:0]             cnt_q, cnt_d;
	logic [CNT_W-1:0]             pos_q, pos_d;
	logic [KEY_BITS-1:0]          key_q, key_d;
	logic signed [SCORE_BITS-1:0] score_q, score_d;
	logic                         res_hit_q, res_hit_d;
	logic signed [31:0]           res_best_q, res_best_d;

	logic                         out_valid_q;
	logic [tkst_pkg::OUT_TDATA_W-1:0] out_data_q;
	logic                         out_hit_q;

	logic                         wr_en;
	logic [IDX_W-1:0]             wr_addr;
	logic [ENT_W-1:0]             wr_data;
	logic [IDX_W-1:0]             rd_addr;
	logic [ENT_W-1:0]             rd_data;

	logic [KEY_BITS-1:0]          rd_key;
	logic signed [SCORE_BITS-1:0] rd_score;
	logic                         in_fire;
	logic                         out_free;
	logic                         full;
	logic [CNT_W-1:0]             ins_start;
	logic signed [31:0]           in_score;

	assign rd_key    = rd_data[ENT_W-1:SCORE_BITS];
	assign rd_score  = $signed(rd_data[SCORE_BITS-1:0]);
	assign in_fire   = s_axis_tvalid && s_axis_tready;
	assign out_free  = !out_valid_q || m_axis_tready;
	assign full      = (cnt_q == CNT_W'(TABLE_DEPTH));
	assign ins_start = full ? CNT_W'(TABLE_DEPTH) : cnt_q;
	assign in_score  = $signed(s_axis_tdata[63:32]);

	assign s_axis_tready = (state_q == tkst_pkg::ST_IDLE);

	// entry storage
	tkst_entry_ram #(
		.DEPTH  (TABLE_DEPTH),
		.WIDTH  (ENT_W),
		.ADDR_W (IDX_W)
	) u_ram (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_data),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	// next state, RAM access and result
	always_comb begin
		state_d    = state_q;
		cnt_d      = cnt_q;
		pos_d      = pos_q;
		key_d      = key_q;
		score_d    = score_q;
		res_hit_d  = res_hit_q;
		res_best_d = res_best_q;
		wr_en      = 1'b0;
		wr_addr    = IDX_W'(pos_q);
		wr_data    = {key_q, score_q};
		rd_addr    = IDX_W'(pos_q - CNT_W'(2));
		case (state_q)
			tkst_pkg::ST_IDLE: begin
				key_d      = KEY_BITS'(s_axis_tdata[31:0]);
				score_d    = SCORE_BITS'(in_score);
				res_hit_d  = 1'b0;
				res_best_d = '0;
				if (s_axis_tuser == tkst_pkg::KIND_LOOKUP) begin
					rd_addr = '0;
				end else begin
					rd_addr = IDX_W'(ins_start - CNT_W'(1));
				end
				if (in_fire) begin
					if (s_axis_tuser == tkst_pkg::KIND_LOOKUP) begin
						pos_d   = '0;
						state_d = (cnt_q == '0) ? tkst_pkg::ST_DONE : tkst_pkg::ST_LKP_CMP;
					end else begin
						pos_d   = ins_start;
						state_d = (cnt_q == '0) ? tkst_pkg::ST_INS_PUT : tkst_pkg::ST_INS_CMP;
					end
				end
			end
			tkst_pkg::ST_INS_CMP: begin
				if (rd_score >= score_q) begin
					// slot found just below the entry read
					if (pos_q != CNT_W'(TABLE_DEPTH)) begin
						wr_en     = 1'b1;
						res_hit_d = 1'b1;
						if (!full) begin
							cnt_d = cnt_q + CNT_W'(1);
						end
					end
					state_d = tkst_pkg::ST_DONE;
				end else begin
					// move the entry down, bottom one drops off a full table
					wr_en   = (pos_q != CNT_W'(TABLE_DEPTH));
					wr_data = rd_data;
					pos_d   = pos_q - CNT_W'(1);
					if (pos_q == CNT_W'(1)) begin
						state_d = tkst_pkg::ST_INS_PUT;
					end
				end
			end
			tkst_pkg::ST_INS_PUT: begin
				// new entry goes to the top
				wr_en     = 1'b1;
				wr_addr   = '0;
				res_hit_d = 1'b1;
				if (!full) begin
					cnt_d = cnt_q + CNT_W'(1);
				end
				state_d = tkst_pkg::ST_DONE;
			end
			tkst_pkg::ST_LKP_CMP: begin
				rd_addr = IDX_W'(pos_q + CNT_W'(1));
				if (rd_key == key_q) begin
					res_hit_d  = 1'b1;
					res_best_d = 32'(rd_score);
					state_d    = tkst_pkg::ST_DONE;
				end else begin
					pos_d = pos_q + CNT_W'(1);
					if (pos_q + CNT_W'(1) == cnt_q) begin
						state_d = tkst_pkg::ST_DONE;
					end
				end
			end
			tkst_pkg::ST_DONE: begin
				if (out_free) begin
					state_d = tkst_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = tkst_pkg::ST_IDLE;
			end
		endcase
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= tkst_pkg::ST_IDLE;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			cnt_q   <= cnt_d;
			if (state_q == tkst_pkg::ST_DONE && out_free) begin
				out_valid_q <= 1'b1;
			end else if (m_axis_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// working and result payload
	always_ff @(posedge clk) begin
		pos_q      <= pos_d;
		key_q      <= key_d;
		score_q    <= score_d;
		res_hit_q  <= res_hit_d;
		res_best_q <= res_best_d;
		if (state_q == tkst_pkg::ST_DONE && out_free) begin
			out_hit_q  <= res_hit_q;
			out_data_q <= {4'b0000, 4'(cnt_q), res_best_q};
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_data_q;
	assign m_axis_tuser  = out_hit_q;

	// checks
	`TKST_ASSERT(a_cnt_bound, clk, arst_n, cnt_q <= CNT_W'(TABLE_DEPTH), "entry count above depth")
	`TKST_ASSERT(a_wr_range, clk, arst_n, !wr_en || (wr_addr < IDX_W'(TABLE_DEPTH - 1)) || (32'(wr_addr) == TABLE_DEPTH - 1), "write outside table")
	`TKST_ASSERT(a_walk_pos, clk, arst_n, state_q != tkst_pkg::ST_INS_CMP || pos_q != '0, "insert walk past top entry")
	`TKST_ASSERT_NEXT(a_cnt_change, clk, arst_n, state_q == tkst_pkg::ST_IDLE || state_q == tkst_pkg::ST_LKP_CMP || state_q == tkst_pkg::ST_DONE, $stable(cnt_q), "count changed outside insert")

endmodule
`default_nettype wire
